@@ src/szc_pkg.sv @@
package szc_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int ZW = 34;  // CORDIC working width (signed)

  localparam logic signed [33:0] Q30_HALF        = 34'sd536870912;
  localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [33:0] DECL_AMP_Q30    = 34'sd439460732;
  localparam logic signed [33:0] Q30_ONE         = 34'sd1073741824;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd843314856;   1: r = 34'sd497837829;  2: r = 34'sd263043836;
      3: r = 34'sd133525158;   4: r = 34'sd67021686;   5: r = 34'sd33543515;
      6: r = 34'sd16775850;    7: r = 34'sd8388437;    8: r = 34'sd4194282;
      9: r = 34'sd2097149;     10: r = 34'sd1048575;   11: r = 34'sd524287;
      12: r = 34'sd262143;     13: r = 34'sd131071;    14: r = 34'sd65535;
      15: r = 34'sd32767;      16: r = 34'sd16383;     17: r = 34'sd8191;
      18: r = 34'sd4095;       19: r = 34'sd2047;      20: r = 34'sd1023;
      21: r = 34'sd511;        22: r = 34'sd255;       23: r = 34'sd127;
      24: r = 34'sd63;         25: r = 34'sd31;        26: r = 34'sd15;
      27: r = 34'sd8;          28: r = 34'sd4;         29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Shift toward zero, as a C division by 2^sh.
  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v, input int sh);
    logic signed [33:0] a;
    a = v[33] ? -v : v;
    a = a >>> sh;
    return v[33] ? -a : a;
  endfunction

  // Product of two Q30 values, rounded half away from zero.
  function automatic logic signed [33:0] rnd_q30(input logic signed [67:0] p);
    logic [67:0] a;
    a = p[67] ? 68'(-p) : 68'(p);
    a = (a + 68'(Q30_HALF)) >> 30;
    return p[67] ? -34'(a) : 34'(a);
  endfunction

endpackage

@@ src/solar_zenith_cosine_unit.sv @@
// Solar zenith cosine unit.
// Input channel: latitude, longitude, zone_meridian (degrees, signed Q16),
// day_of_year and second_of_day, qualified by in_valid / in_stall.
// Output channel: cos_zenith (signed Q16, saturated to +-1) on
// out_valid / out_stall.
// An item is taken at a clock edge with valid high and stall low.
// Throughput: one item per cycle while no stall holds the pipe. The pipe
// holds 2*CORDIC_STAGES + 10 register stages (default 46): five stages of
// angle scaling, the fold, latitude/day/hour CORDICs in parallel, the
// declination product, the declination CORDIC, two product stages and the
// rounding stage. The pipe length is set by the two chained CORDICs.
// The whole pipe advances as one when the output register is empty or is
// being taken; the input stall is therefore out_valid && out_stall, and a
// stall holds every item in place with nothing lost or repeated.
// Reset (rst, synchronous) clears all valid bits; payload is not cleared.
module solar_zenith_cosine_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [23:0]  latitude,
  input  logic signed [24:0]  longitude,
  input  logic signed [24:0]  zone_meridian,
  input  logic        [8:0]   day_of_year,
  input  logic        [16:0]  second_of_day,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [17:0]  cos_zenith
);
  import szc_pkg::*;

  localparam int DEPTH = 2 * CORDIC_STAGES + 10;

  // Reciprocals ceil(2^s / d), exact over the operand ranges used here.
  localparam logic [27:0] RECIP_45   = 28'd190887436;  // s = 33
  localparam logic [19:0] RECIP_365  = 20'd735440;     // s = 28
  localparam logic [17:0] RECIP_3600 = 18'd149131;     // s = 29

  logic adv;
  logic [DEPTH-1:0] vld;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[DEPTH-1];

  // Advance valid bits with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stages 1 to 5: angles as binary turns. Divide magnitudes by reciprocal
  // multiplication so every quotient truncates toward zero. Use
  // 8192/45 = 182 + 2/45 and 2^30/365 = 2941758 + 154/365 to keep the
  // reciprocal products narrow.
  logic [5:0]         hour1;
  logic               lat_neg1, lat_neg2, hr_neg3, hr_neg4;
  logic [23:0]        lat_abs1;
  logic signed [25:0] dm1;
  logic [18:0]        day_nb1;
  logic [31:0]        day_na1, lat_q2, day_t2, lat_t3, day_t3, lat_t4, day_t4, hr_q4;
  logic signed [26:0] hr_m2;
  logic [25:0]        hr_abs3;
  logic [35:0]        sec_p;
  logic [11:0]        day_num;
  logic [52:0]        lat_rp;
  logic [38:0]        day_rp;
  logic [54:0]        hr_rp;
  logic [31:0]        lat_t, day_t, hr_t;

  always_comb begin
    sec_p   = 36'(second_of_day) * 36'(RECIP_3600);
    day_num = {1'b0, day_of_year, 2'b00} + 12'd45;
    lat_rp  = 53'({lat_abs1, 1'b0}) * 53'(RECIP_45);
    day_rp  = 39'(day_nb1) * 39'(RECIP_365);
    hr_rp   = 55'({hr_abs3, 1'b0}) * 55'(RECIP_45);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // hour, latitude magnitude, meridian offset, day numerator parts
      hour1    <= sec_p[34:29];
      lat_neg1 <= latitude[23];
      lat_abs1 <= latitude[23] ? 24'(-latitude) : 24'(latitude);
      dm1      <= 26'(zone_meridian) - 26'(longitude);
      day_nb1  <= 19'(day_num) * 19'd154;
      day_na1  <= 32'(day_num) * 32'd2941758;
      // hour-angle numerator over 65536, latitude quotient, day turns
      hr_m2    <= (27'($signed({1'b0, hour1})) - 27'sd12) * 27'sd983040 + 27'(dm1);
      lat_neg2 <= lat_neg1;
      lat_q2   <= 32'(lat_abs1) * 32'd182 + 32'(lat_rp[52:33]);
      day_t2   <= day_na1 + 32'(day_rp[38:28]);
      // hour-angle magnitude; restore the latitude sign
      hr_neg3  <= hr_m2[26];
      hr_abs3  <= hr_m2[26] ? 26'(-hr_m2) : 26'(hr_m2);
      lat_t3   <= lat_neg2 ? -lat_q2 : lat_q2;
      day_t3   <= day_t2;
      // hour-angle quotient
      hr_neg4  <= hr_neg3;
      hr_q4    <= 32'(hr_abs3) * 32'd182 + 32'(hr_rp[54:33]);
      lat_t4   <= lat_t3;
      day_t4   <= day_t3;
      // restore the hour-angle sign
      lat_t    <= lat_t4;
      day_t    <= day_t4;
      hr_t     <= hr_neg4 ? -hr_q4 : hr_q4;
    end
  end

  // Stage 6: fold to a quarter turn and scale to radians.
  logic signed [33:0] lat_zc, day_zc, hr_zc, lat_z, day_z, hr_z;
  logic lat_fc, day_fc, hr_fc, lat_f, day_f, hr_f;

  szc_fold u_fl (.t(lat_t), .z(lat_zc), .flip(lat_fc));
  szc_fold u_fd (.t(day_t), .z(day_zc), .flip(day_fc));
  szc_fold u_fh (.t(hr_t),  .z(hr_zc),  .flip(hr_fc));

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_z <= lat_zc; lat_f <= lat_fc;
      day_z <= day_zc; day_f <= day_fc;
      hr_z  <= hr_zc;  hr_f  <= hr_fc;
    end
  end

  // First CORDIC bank.
  logic signed [33:0] coslat, sinlat, cd, sd_unused, cosh, sinh_unused;

  szc_cordic u_clat (.clk, .adv, .z_in(lat_z), .flip_in(lat_f),
                     .c_out(coslat), .s_out(sinlat));
  szc_cordic u_cday (.clk, .adv, .z_in(day_z), .flip_in(day_f),
                     .c_out(cd), .s_out(sd_unused));
  szc_cordic u_chr  (.clk, .adv, .z_in(hr_z), .flip_in(hr_f),
                     .c_out(cosh), .s_out(sinh_unused));

  // Declination product; latitude and hour terms wait alongside.
  logic signed [33:0] decl;
  logic signed [33:0] lc_d [CORDIC_STAGES+1];
  logic signed [33:0] ls_d [CORDIC_STAGES+1];
  logic signed [33:0] hc_d [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      decl    <= -rnd_q30(68'(DECL_AMP_Q30) * 68'(cd));
      lc_d[0] <= coslat;
      ls_d[0] <= sinlat;
      hc_d[0] <= cosh;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        lc_d[i+1] <= lc_d[i];
        ls_d[i+1] <= ls_d[i];
        hc_d[i+1] <= hc_d[i];
      end
    end
  end

  // Declination CORDIC, no fold needed.
  logic signed [33:0] cosdecl, sindecl;
  szc_cordic u_cdec (.clk, .adv, .z_in(decl), .flip_in(1'b0),
                     .c_out(cosdecl), .s_out(sindecl));

  // Products over two stages, then round to Q16 and saturate.
  logic signed [33:0] p_ld, p_ss, ch_r, p_tot;
  logic signed [17:0] res;
  logic signed [33:0] a16, q16;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ld  <= rnd_q30(68'(lc_d[CORDIC_STAGES]) * 68'(cosdecl));
      p_ss  <= rnd_q30(68'(ls_d[CORDIC_STAGES]) * 68'(sindecl));
      ch_r  <= hc_d[CORDIC_STAGES];
      p_tot <= rnd_q30(68'(p_ld) * 68'(ch_r)) + p_ss;
      res   <= 18'(q16);
    end
  end

  always_comb begin
    a16 = p_tot[33] ? -p_tot : p_tot;
    a16 = (a16 + 34'sd8192) >>> 14;
    q16 = p_tot[33] ? -a16 : a16;
    if (q16 > 34'sd65536)  q16 = 34'sd65536;
    if (q16 < -34'sd65536) q16 = -34'sd65536;
  end

  assign cos_zenith = res;

  // Output register holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cos_zenith))
    else $error("result changed under stall");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cos_zenith <= 18'sd65536) && (cos_zenith >= -18'sd65536))
    else $error("result out of range");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
endmodule

@@ src/szc_cordic.sv @@
module szc_cordic (
  input  logic                clk,
  input  logic                adv,
  input  logic signed [33:0]  z_in,
  input  logic                flip_in,
  output logic signed [33:0]  c_out,
  output logic signed [33:0]  s_out
);
  import szc_pkg::*;

  logic signed [33:0] x [CORDIC_STAGES+1];
  logic signed [33:0] y [CORDIC_STAGES+1];
  logic signed [33:0] z [CORDIC_STAGES+1];
  logic               f [CORDIC_STAGES+1];

  assign x[0] = CORDIC_GAIN_INV;
  assign y[0] = '0;
  assign z[0] = z_in;
  assign f[0] = flip_in;

  // One rotation per register stage; advance only when the pipe moves.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        f[i+1] <= f[i];
        if (!z[i][33]) begin
          x[i+1] <= x[i] - shr_tz(y[i], i);
          y[i+1] <= y[i] + shr_tz(x[i], i);
          z[i+1] <= z[i] - atan_q30(i);
        end else begin
          x[i+1] <= x[i] + shr_tz(y[i], i);
          y[i+1] <= y[i] - shr_tz(x[i], i);
          z[i+1] <= z[i] + atan_q30(i);
        end
      end
    end
  end

  assign c_out = f[CORDIC_STAGES] ? -x[CORDIC_STAGES] : x[CORDIC_STAGES];
  assign s_out = f[CORDIC_STAGES] ? -y[CORDIC_STAGES] : y[CORDIC_STAGES];
endmodule

@@ src/szc_fold.sv @@
module szc_fold (
  input  logic [31:0]         t,
  output logic signed [33:0]  z,
  output logic                flip
);
  import szc_pkg::*;

  logic signed [31:0] sv;
  logic signed [65:0] p;

  // Fold angles beyond a quarter turn by half a turn; scale turns to radians.
  always_comb begin
    flip = ($signed(t) > 32'sd1073741824) || ($signed(t) < -32'sd1073741824);
    sv   = flip ? $signed(t ^ 32'h8000_0000) : $signed(t);
    p    = 66'(sv) * 66'(HALF_PI_Q30);
    if (p[65]) z = 34'(-((-p) >>> 30));
    else       z = 34'(p >>> 30);
  end
endmodule
